// ===== hdl/led64_pkg.sv =====
// shared types, tables and round functions for the led-64 cipher pipeline
`timescale 1ns / 1ps
`default_nettype none

package led64_pkg;

  // one pipeline slot: valid flag, direction and the 4x4 nibble state
  typedef struct packed {
    logic        valid;
    logic        op;
    logic [63:0] state;
  } stage_t;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam int RC_LEN = 48;

  localparam logic [3:0] SBOX_FWD [16] = '{
    4'd12, 4'd5, 4'd6, 4'd11, 4'd9, 4'd0, 4'd10, 4'd13,
    4'd3, 4'd14, 4'd15, 4'd8, 4'd4, 4'd7, 4'd1, 4'd2
  };

  localparam logic [3:0] SBOX_INV [16] = '{
    4'd5, 4'd14, 4'd15, 4'd8, 4'd12, 4'd1, 4'd2, 4'd13,
    4'd11, 4'd4, 4'd6, 4'd3, 4'd0, 4'd7, 4'd9, 4'd10
  };

  localparam logic [3:0] MIX_FWD [4][4] = '{
    '{4'd4, 4'd1, 4'd2, 4'd2},
    '{4'd8, 4'd6, 4'd5, 4'd6},
    '{4'd11, 4'd14, 4'd10, 4'd9},
    '{4'd2, 4'd2, 4'd15, 4'd11}
  };

  localparam logic [3:0] MIX_INV [4][4] = '{
    '{4'd12, 4'd12, 4'd13, 4'd4},
    '{4'd3, 4'd8, 4'd4, 4'd5},
    '{4'd7, 4'd6, 4'd2, 4'd14},
    '{4'd13, 4'd9, 4'd9, 4'd13}
  };

  localparam logic [5:0] RC_TABLE [RC_LEN] = '{
    6'h01, 6'h03, 6'h07, 6'h0F, 6'h1F, 6'h3E, 6'h3D, 6'h3B, 6'h37, 6'h2F,
    6'h1E, 6'h3C, 6'h39, 6'h33, 6'h27, 6'h0E, 6'h1D, 6'h3A, 6'h35, 6'h2B,
    6'h16, 6'h2C, 6'h18, 6'h30, 6'h21, 6'h02, 6'h05, 6'h0B, 6'h17, 6'h2E,
    6'h1C, 6'h38, 6'h31, 6'h23, 6'h06, 6'h0D, 6'h1B, 6'h36, 6'h2D, 6'h1A,
    6'h34, 6'h29, 6'h12, 6'h24, 6'h08, 6'h11, 6'h22, 6'h04
  };

  // nibble k = 4*row+col sits at bits 63-4k downward
  function automatic logic [3:0] nib(input logic [63:0] s, input int k);
    return s[63-4*k -: 4];
  endfunction

  // multiply in gf(16) modulo x^4+x+1
  function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] acc;
    logic [3:0] x;
    acc = 4'd0;
    x   = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc = acc ^ x;
      x = x[3] ? ({x[2:0], 1'b0} ^ 4'h3) : {x[2:0], 1'b0};
    end
    return acc;
  endfunction

  function automatic logic [63:0] add_consts(input logic [63:0] s, input logic [5:0] rc);
    logic [63:0] r;
    r = s;
    r[63-4*0 -: 4]  = r[63-4*0 -: 4] ^ 4'd4;
    r[63-4*4 -: 4]  = r[63-4*4 -: 4] ^ 4'd5;
    r[63-4*8 -: 4]  = r[63-4*8 -: 4] ^ 4'd2;
    r[63-4*12 -: 4] = r[63-4*12 -: 4] ^ 4'd3;
    r[63-4*1 -: 4]  = r[63-4*1 -: 4] ^ {1'b0, rc[5:3]};
    r[63-4*9 -: 4]  = r[63-4*9 -: 4] ^ {1'b0, rc[5:3]};
    r[63-4*5 -: 4]  = r[63-4*5 -: 4] ^ {1'b0, rc[2:0]};
    r[63-4*13 -: 4] = r[63-4*13 -: 4] ^ {1'b0, rc[2:0]};
    return r;
  endfunction

  // sbox then rotate row r left by r
  function automatic logic [63:0] sub_shift(input logic [63:0] s);
    logic [63:0] r;
    r = '0;
    for (int row = 0; row < 4; row++) begin
      for (int col = 0; col < 4; col++) begin
        r[63-4*(4*row+col) -: 4] = SBOX_FWD[nib(s, 4*row + ((col + row) % 4))];
      end
    end
    return r;
  endfunction

  // undo sub_shift: rotate row r right by r, then inverse sbox
  function automatic logic [63:0] inv_sub_shift(input logic [63:0] s);
    logic [63:0] r;
    r = '0;
    for (int row = 0; row < 4; row++) begin
      for (int col = 0; col < 4; col++) begin
        r[63-4*(4*row + ((col + row) % 4)) -: 4] = SBOX_INV[nib(s, 4*row+col)];
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] mix(input logic [63:0] s, input logic inverse);
    logic [63:0] r;
    logic [3:0]  acc;
    r = '0;
    for (int col = 0; col < 4; col++) begin
      for (int row = 0; row < 4; row++) begin
        acc = 4'd0;
        for (int k = 0; k < 4; k++) begin
          acc = acc ^ gf_mul(inverse ? MIX_INV[row][k] : MIX_FWD[row][k],
                             nib(s, 4*k+col));
        end
        r[63-4*(4*row+col) -: 4] = acc;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/led64_round.sv =====
// one registered round stage, encrypt or decrypt, with optional key add
`timescale 1ns / 1ps
`default_nettype none

module led64_round
  import led64_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        key_add,
  input  wire logic [5:0]  rc_fwd,
  input  wire logic [5:0]  rc_inv,
  input  wire logic [63:0] key,
  input  wire stage_t      in_stage,
  output stage_t           out_stage
);

  logic [63:0] keyed;
  logic [63:0] fwd_state;
  logic [63:0] inv_state;

  always_comb begin
    keyed     = in_stage.state ^ (key_add ? key : 64'd0);
    fwd_state = mix(sub_shift(add_consts(keyed, rc_fwd)), 1'b0);
    inv_state = add_consts(inv_sub_shift(mix(keyed, 1'b1)), rc_inv);
  end

  // only the valid flag is reset, the payload just follows the enable
  always_ff @(posedge clk) begin
    if (en) begin
      out_stage.op    <= in_stage.op;
      out_stage.state <= (in_stage.op == OP_DECRYPT) ? inv_state : fwd_state;
    end
    if (rst) begin
      out_stage.valid <= 1'b0;
    end else if (en) begin
      out_stage.valid <= in_stage.valid;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/led64_block_cipher.sv =====
// top level of the led-64 cipher: key register, round pipeline, output register
`timescale 1ns / 1ps
`default_nettype none

// LED-64 encrypt/decrypt engine. One register stage per round, so a block is
// accepted in every cycle unless output back-pressure has filled the pipeline,
// and its result passes through every round stage and then the output register
// that holds the final key add. tuser[0] selects encrypt (0) or decrypt (1).
// The key comes straight from the key register, so write it only while no block
// is in flight. Back-pressure on the output stalls the pipeline and empty slots
// still fill, so nothing is lost or repeated.
module led64_block_cipher
  import led64_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [63:0] cfg_data,   // cipher_key
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,    // block_in
  input  wire logic [0:0]  s_tuser,    // operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata     // block_out
);

  localparam int STEPS = ROUNDS / 4;
  localparam int NR    = STEPS * 4;

  logic [63:0] cipher_key;
  stage_t      st [NR+1];
  logic        en [NR];
  logic        out_en;
  logic        out_valid;
  logic [63:0] out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      cipher_key <= cfg_data;
    end
  end

  assign st[0]    = '{valid: s_tvalid, op: s_tuser[0], state: s_tdata};
  assign s_tready = en[0];

  // a slot moves when it is empty or its successor moves
  assign out_en = !out_valid || m_tready;

  for (genvar p = 0; p < NR; p++) begin : g_round
    localparam int RF = p % RC_LEN;
    localparam int RI = (NR - 1 - p) % RC_LEN;

    if (p == NR - 1) begin : g_last
      assign en[p] = !st[p+1].valid || out_en;
    end else begin : g_mid
      assign en[p] = !st[p+1].valid || en[p+1];
    end

    led64_round u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (en[p]),
      .key_add   ((p % 4) == 0),
      .rc_fwd    (RC_TABLE[RF]),
      .rc_inv    (RC_TABLE[RI]),
      .key       (cipher_key),
      .in_stage  (st[p]),
      .out_stage (st[p+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= st[NR].valid;
    end
  end

  // closing key add for both directions
  always_ff @(posedge clk) begin
    if (out_en) begin
      out_data <= st[NR].state ^ cipher_key;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // the input only blocks when the output beat is held back
  a_block_only_on_output_stall : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output back-pressure");

  // a finished block moving out of the last round shows up on the output
  a_last_stage_reaches_output : assert property (@(posedge clk) disable iff (rst)
    (out_en && st[NR].valid) |=> m_tvalid)
    else $error("block dropped between last round and output");

  // an idle input cycle leaves a bubble in the first stage
  a_bubble_enters : assert property (@(posedge clk) disable iff (rst)
    (en[0] && !s_tvalid) |=> !st[1].valid)
    else $error("first stage became valid without an input beat");

endmodule

`default_nettype wire

// ===== test/led64_cipher_checker.sv =====
// checker for the led-64 cipher: tracks the key, predicts every block and compares results
`timescale 1ns / 1ps

module led64_cipher_checker
  import led64_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,    // block_in
  input  logic [0:0]  s_tuser,    // operation
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,    // block_out
  output int          mismatches,
  output int          outstanding
);

  typedef struct {
    logic        op;
    logic [63:0] blk_in;
    logic [63:0] blk_out;
  } cipher_job_t;

  cipher_job_t expected_blocks[$];
  logic [63:0] key_copy;

  function automatic logic [3:0] gf16_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] p;
    logic [3:0] x;
    p = 4'd0;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = x[3] ? ({x[2:0], 1'b0} ^ 4'h3) : {x[2:0], 1'b0};
    end
    return p;
  endfunction

  // column 0 carries the key-size constant, column 1 the split round constant
  function automatic logic [63:0] round_consts(input logic [63:0] st, input int r);
    logic [5:0]  rc;
    logic [63:0] mask;
    rc = RC_TABLE[r % RC_LEN];
    mask = '0;
    mask[63-4*0 -: 4]  = 4'd4;
    mask[63-4*4 -: 4]  = 4'd5;
    mask[63-4*8 -: 4]  = 4'd2;
    mask[63-4*12 -: 4] = 4'd3;
    mask[63-4*1 -: 4]  = {1'b0, rc[5:3]};
    mask[63-4*9 -: 4]  = {1'b0, rc[5:3]};
    mask[63-4*5 -: 4]  = {1'b0, rc[2:0]};
    mask[63-4*13 -: 4] = {1'b0, rc[2:0]};
    return st ^ mask;
  endfunction

  // forward: sbox + row rotate + column mix; inverse undoes them in reverse order
  function automatic logic [63:0] round_core(input logic [63:0] st, input logic inv);
    logic [3:0]  a[16];
    logic [3:0]  b[16];
    logic [3:0]  acc;
    logic [63:0] res;
    for (int k = 0; k < 16; k++) a[k] = st[63-4*k -: 4];
    if (!inv) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          b[4*r+c] = SBOX_FWD[a[4*r + ((c + r) % 4)]];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) begin
          acc = 4'd0;
          for (int j = 0; j < 4; j++) acc = acc ^ gf16_mul(MIX_FWD[r][j], b[4*j+c]);
          a[4*r+c] = acc;
        end
    end else begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) begin
          acc = 4'd0;
          for (int j = 0; j < 4; j++) acc = acc ^ gf16_mul(MIX_INV[r][j], a[4*j+c]);
          b[4*r+c] = acc;
        end
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          a[4*r + ((c + r) % 4)] = SBOX_INV[b[4*r+c]];
    end
    for (int k = 0; k < 16; k++) res[63-4*k -: 4] = a[k];
    return res;
  endfunction

  function automatic logic [63:0] led_cipher_block(input logic op, input logic [63:0] blk,
                                                   input logic [63:0] key);
    logic [63:0] st;
    int          nsteps;
    nsteps = ROUNDS / 4;
    st = blk;
    if (op == OP_ENCRYPT) begin
      st = st ^ key;
      for (int i = 0; i < nsteps; i++) begin
        for (int j = 0; j < 4; j++) begin
          st = round_consts(st, 4*i + j);
          st = round_core(st, 1'b0);
        end
        st = st ^ key;
      end
    end else begin
      for (int i = nsteps; i > 0; i--) begin
        st = st ^ key;
        for (int j = 4; j > 0; j--) begin
          st = round_core(st, 1'b1);
          st = round_consts(st, 4*(i-1) + (j-1));
        end
      end
      st = st ^ key;
    end
    return st;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
    key_copy    = '0;
  end

  always @(posedge clk) begin
    cipher_job_t job;
    if (rst) begin
      key_copy = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch($sformatf("unexpected output beat %h", m_tdata));
        end else begin
          job = expected_blocks.pop_front();
          if (m_tdata !== job.blk_out)
            report_mismatch($sformatf("block_out %h, expected %h (op %0d, block_in %h)",
                                      m_tdata, job.blk_out, job.op, job.blk_in));
        end
      end
      if (cfg_valid && cfg_ready) key_copy = cfg_data;
      if (s_tvalid && s_tready) begin
        job.op      = s_tuser[0];
        job.blk_in  = s_tdata;
        job.blk_out = led_cipher_block(s_tuser[0], s_tdata, key_copy);
        expected_blocks.push_back(job);
      end
    end
    outstanding = expected_blocks.size();
  end

endmodule

// ===== test/led64_block_cipher_tb.sv =====
// testbench top for the led-64 cipher: stimulus, idling mixes, watchdog and verdict
`timescale 1ns / 1ps

module led64_block_cipher_tb
  import led64_pkg::*;
();

  localparam int ROUNDS       = 32;
  localparam int HOLD_CYCLES  = 150;
  localparam int STUCK_LIMIT  = 3000;
  localparam int PHASE_BLOCKS = 267;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;    // block_in
  logic [0:0]  s_tuser;    // operation
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;    // block_out

  int mismatches;
  int outstanding;
  int snd_idle_pct;
  int rcv_stall_pct;
  logic hold_off;
  int stuck_cycles;
  int n_encrypt;
  int n_decrypt;
  int n_keys;

  led64_block_cipher #(.ROUNDS(ROUNDS)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  led64_cipher_checker #(.ROUNDS(ROUNDS)) chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= !hold_off && ($urandom_range(99) >= rcv_stall_pct);
  end

  // no beat on any channel for too long means the block is hung
  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d blocks outstanding",
               stuck_cycles, outstanding);
      $display("led64_block_cipher_tb NOT OK");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic set_mode(input int snd, input int rcv);
    snd_idle_pct = snd;
    rcv_stall_pct <= rcv;
  endtask

  // lower valid and wait until every expected block has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_key(input logic [63:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_keys++;
  endtask

  task automatic send_block(input logic op, input logic [63:0] blk);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= blk;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (op == OP_ENCRYPT) n_encrypt++;
    else n_decrypt++;
  endtask

  function automatic logic [63:0] rand_block();
    logic [63:0] one_hot;
    one_hot = 64'd1 << $urandom_range(63);
    case ($urandom_range(15))
      0: return 64'd0;
      1: return ~64'd0;
      2: return one_hot;
      3: return ~one_hot;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    m_tready      = 1'b0;
    hold_off      = 1'b0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    n_encrypt     = 0;
    n_decrypt     = 0;
    n_keys        = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset key, then all-ones key, then a counting key
    send_block(OP_ENCRYPT, 64'h0);
    send_block(OP_DECRYPT, 64'h0);
    send_block(OP_ENCRYPT, ~64'h0);
    send_block(OP_DECRYPT, ~64'h0);
    set_key(~64'h0);
    send_block(OP_ENCRYPT, 64'h0);
    send_block(OP_DECRYPT, 64'h0);
    send_block(OP_ENCRYPT, ~64'h0);
    send_block(OP_DECRYPT, ~64'h0);
    send_block(OP_ENCRYPT, 64'h5555_5555_5555_5555);
    send_block(OP_DECRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
    set_key(64'h0123_4567_89AB_CDEF);
    send_block(OP_ENCRYPT, 64'h0);
    send_block(OP_ENCRYPT, 64'hFEDC_BA98_7654_3210);
    send_block(OP_DECRYPT, 64'h0);
    send_block(OP_DECRYPT, 64'h0123_4567_89AB_CDEF);
    send_block(OP_ENCRYPT, 64'h8000_0000_0000_0000);
    send_block(OP_DECRYPT, 64'h0000_0000_0000_0001);
    send_block(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);

    for (int p = 0; p < 5; p++) begin
      case (p)
        1: set_key(~64'h0);
        3: set_key(64'h0);
        default: set_key({$urandom, $urandom});
      endcase
      case (p)
        1: set_mode(51, 0);
        2: set_mode(0, 51);
        3: set_mode(19, 19);
        default: set_mode(0, 0);
      endcase
      if (p == 0) begin
        // output held off while blocks keep coming, so the pipeline backs up
        fork
          begin
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      repeat (PHASE_BLOCKS) send_block(1'($urandom_range(1)), rand_block());
    end

    set_mode(0, 0);
    drain();
    repeat (40) @(negedge clk);

    $display("ran %0d blocks (%0d encrypt, %0d decrypt) under %0d key writes plus the reset key",
             n_encrypt + n_decrypt, n_encrypt, n_decrypt, n_keys);
    $display("idle/stall mixes on both sides and a %0d-cycle output hold-off", HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("led64_block_cipher_tb OK");
    end else begin
      $display("led64_block_cipher_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== led64_block_cipher.f =====
hdl/led64_pkg.sv
hdl/led64_round.sv
hdl/led64_block_cipher.sv
test/led64_cipher_checker.sv
test/led64_block_cipher_tb.sv
